>>> hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned DefValueWidth = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_DIV0 = 2'd1,
    STS_OVF  = 2'd2
  } rau_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_NORM,
    S_GCD,
    S_DIV,
    S_FIN,
    S_DONE
  } rau_state_e;

endpackage

`default_nettype wire

>>> hw/rtl/rau_in_if.sv
// ----------------------------------------------------------------------------
// rau_in_if
// Operand channel: operation and two fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [1:0]   operation;
  logic [W-1:0] a_numerator;
  logic [W-2:0] a_denominator;
  logic [W-1:0] b_numerator;
  logic [W-2:0] b_denominator;

  modport source (
    output valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    input  ready
  );
  modport sink (
    input  valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/rau_out_if.sv
// ----------------------------------------------------------------------------
// rau_out_if
// Result channel: reduced fraction and status, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_out_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] result_numerator;
  logic [W-2:0] result_denominator;
  logic [1:0]   status;

  modport source (
    output valid, result_numerator, result_denominator, status,
    input  ready
  );
  modport sink (
    input  valid, result_numerator, result_denominator, status,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/rau_seq.sv
// ----------------------------------------------------------------------------
// rau_seq
// Sequencer around one shared multiplier, a binary gcd loop and a
// two-lane restoring divider that reduces the raw fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_seq
  import rau_pkg::*;
#(
  parameter int unsigned W = DefValueWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [1:0]   op_i,
  input  wire logic [W-1:0] an_i,
  input  wire logic [W-2:0] ad_i,
  input  wire logic [W-1:0] bn_i,
  input  wire logic [W-2:0] bd_i,
  output logic              idle_o,
  output logic              done_valid_o,
  input  wire logic         done_ready_i,
  output logic [W-1:0]      res_num_o,
  output logic [W-2:0]      res_den_o,
  output logic [1:0]        res_status_o
);

  localparam int unsigned DW = 2 * W;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned KW = CW + 1;
  localparam logic [CW-1:0] LastCnt = CW'(DW - 1);
  localparam logic [DW-1:0] Lim = DW'(1) << (W - 1);

  rau_state_e state_q, state_d;

  rau_op_e       op_q;
  logic [W-1:0]  an_q, bn_q;
  logic [W-2:0]  ad_q, bd_q;
  logic [DW-1:0] p_q, p_d;
  logic signed [DW:0] acc_q, acc_d;
  logic [DW-1:0] nm_q, nm_d, dm_q, dm_d;
  logic          neg_q, neg_d;
  logic [DW-1:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [KW-1:0] k_q, k_d;
  logic [DW-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  num_q, num_d;
  logic [W-2:0]  den_q, den_d;
  logic [1:0]    sts_q, sts_d;

  logic          bad_in;
  logic [W-1:0]  an_mag, bn_mag, mul_a, mul_b;
  logic [DW-1:0] prod;
  logic          an_neg, bn_neg, term_neg;
  logic signed [DW:0] term;
  logic [DW-1:0] acc_mag;
  logic [DW:0]   tn, td;
  logic          qn_bit, qd_bit;
  logic          ovf;

  assign bad_in = (ad_i == '0) || (bd_i == '0) ||
                  ((rau_op_e'(op_i) == OP_DIV) && (bn_i == '0));

  assign an_neg = an_q[W-1];
  assign bn_neg = bn_q[W-1];
  assign an_mag = an_neg ? (-an_q) : an_q;
  assign bn_mag = bn_neg ? (-bn_q) : bn_q;
  assign prod   = DW'(mul_a) * DW'(mul_b);
  assign acc_mag = acc_q[DW] ? DW'(-acc_q) : acc_q[DW-1:0];
  assign term   = term_neg ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});

  assign tn     = {rn_q, nm_q[DW-1]};
  assign td     = {rd_q, dm_q[DW-1]};
  assign qn_bit = tn >= {1'b0, g_q};
  assign qd_bit = td >= {1'b0, g_q};

  assign ovf = (dm_q > Lim - DW'(1)) ||
               (neg_q ? (nm_q > Lim) : (nm_q > Lim - DW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = bad_in ? S_DONE : S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_NORM;
      S_NORM: state_d = (acc_mag == '0) ? S_DONE : S_GCD;
      S_GCD:  if (u_q == v_q) state_d = S_DIV;
      S_DIV:  if (cnt_q == LastCnt) state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: if (done_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    p_d = p_q; acc_d = acc_q; nm_d = nm_q; dm_d = dm_q; neg_d = neg_q;
    u_d = u_q; v_d = v_q; g_d = g_q; k_d = k_q;
    rn_d = rn_q; rd_d = rd_q; cnt_d = cnt_q;
    num_d = num_q; den_d = den_q; sts_d = sts_q;
    mul_a = an_mag;
    mul_b = {1'b0, bd_q};
    term_neg = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        num_d = '0;
        den_d = (W-1)'(1);
        sts_d = STS_DIV0;
      end
      S_MUL0: begin
        mul_a = an_mag;
        mul_b = (op_q == OP_MUL) ? bn_mag : {1'b0, bd_q};
        p_d   = prod;
      end
      S_MUL1: begin
        term_neg = an_neg ^ ((op_q == OP_MUL) || (op_q == OP_DIV) ? bn_neg : 1'b0);
        acc_d = term;
        mul_a = bn_mag;
        mul_b = {1'b0, ad_q};
        p_d   = prod;
      end
      S_MUL2: begin
        term_neg = bn_neg ^ (op_q == OP_SUB);
        if ((op_q == OP_ADD) || (op_q == OP_SUB)) acc_d = acc_q + term;
        mul_a = {1'b0, ad_q};
        mul_b = (op_q == OP_DIV) ? bn_mag : {1'b0, bd_q};
        p_d   = prod;
      end
      S_NORM: begin
        nm_d  = acc_mag;
        dm_d  = p_q;
        neg_d = acc_q[DW];
        u_d   = acc_mag;
        v_d   = p_q;
        k_d   = '0;
        num_d = '0;
        den_d = (W-1)'(1);
        sts_d = STS_OK;
      end
      S_GCD: begin
        priority if (u_q == v_q) begin
          g_d   = u_q << k_q;
          rn_d  = '0;
          rd_d  = '0;
          cnt_d = '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      S_DIV: begin
        rn_d  = qn_bit ? DW'(tn - {1'b0, g_q}) : tn[DW-1:0];
        rd_d  = qd_bit ? DW'(td - {1'b0, g_q}) : td[DW-1:0];
        nm_d  = {nm_q[DW-2:0], qn_bit};
        dm_d  = {dm_q[DW-2:0], qd_bit};
        cnt_d = cnt_q + CW'(1);
      end
      S_FIN: begin
        if (ovf) begin
          num_d = '0;
          den_d = (W-1)'(1);
          sts_d = STS_OVF;
        end else begin
          num_d = neg_q ? W'(-nm_q) : nm_q[W-1:0];
          den_d = dm_q[W-2:0];
          sts_d = STS_OK;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      op_q <= rau_op_e'(op_i);
      an_q <= an_i;
      ad_q <= ad_i;
      bn_q <= bn_i;
      bd_q <= bd_i;
    end
    p_q <= p_d; acc_q <= acc_d; nm_q <= nm_d; dm_q <= dm_d; neg_q <= neg_d;
    u_q <= u_d; v_q <= v_d; g_q <= g_d; k_q <= k_d;
    rn_q <= rn_d; rd_q <= rd_d; cnt_q <= cnt_d;
    num_q <= num_d; den_q <= den_d; sts_q <= sts_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign done_valid_o = (state_q == S_DONE);
  assign res_num_o    = num_q;
  assign res_den_o    = den_q;
  assign res_status_o = sts_q;

`ifndef SYNTH
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD) |-> ((u_q != '0) && (v_q != '0)))
    else $error("gcd operand reached zero");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (g_q != '0))
    else $error("divide by zero gcd");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && idle_o) |=> !idle_o)
    else $error("start not taken");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_valid_o && !done_ready_i) |=> (done_valid_o && $stable(res_num_o) &&
      $stable(res_den_o) && $stable(res_status_o)))
    else $error("result changed while held");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Add, subtract, multiply or divide two fractions and reduce the result.
// ----------------------------------------------------------------------------
// flow: bad operands go straight to the result beat, a zero result skips the
// gcd and the divider, any other result runs the binary gcd loop, then the divider
// throughput: one beat at a time, ready only while the sequencer is idle
// reset: asynchronous active low, clears the sequencer and the output valid
`default_nettype none

module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  logic                   idle, start, done_valid, done_ready;
  logic [VALUE_WIDTH-1:0] res_num;
  logic [VALUE_WIDTH-2:0] res_den;
  logic [1:0]             res_status;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_num_q;
  logic [VALUE_WIDTH-2:0] out_den_q;
  logic [1:0]             out_sts_q;

  assign in_i.ready = idle;
  assign start      = in_i.valid && idle;
  assign done_ready = !out_valid_q || out_o.ready;

  rau_seq #(
    .W (VALUE_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (in_i.operation),
    .an_i         (in_i.a_numerator),
    .ad_i         (in_i.a_denominator),
    .bn_i         (in_i.b_numerator),
    .bd_i         (in_i.b_denominator),
    .idle_o       (idle),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .res_num_o    (res_num),
    .res_den_o    (res_den),
    .res_status_o (res_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_ready) begin
      out_valid_q <= done_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ready && done_valid) begin
      out_num_q <= res_num;
      out_den_q <= res_den;
      out_sts_q <= res_status;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_numerator   = out_num_q;
  assign out_o.result_denominator = out_den_q;
  assign out_o.status             = out_sts_q;

endmodule

`default_nettype wire

>>> tb/rational_arithmetic_unit_core_test.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_test
// Drives operand beats with bursts and gaps, stalls the result side on its own
// pattern, predicts every reduced fraction and status, and checks each result
// beat in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class rau_scoreboard;
  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  sts;
  } frac_t;

  frac_t pending[$];
  int    checked;

  function frac_t reduce_fraction(rau_pkg::rau_op_e op, logic [31:0] an_b,
                                  logic [30:0] ad_b, logic [31:0] bn_b,
                                  logic [30:0] bd_b);
    longint an, ad, bn, bd, rn, rd, p, q, r;
    bit     neg;
    frac_t  f;
    an = longint'($signed(an_b));
    bn = longint'($signed(bn_b));
    ad = longint'({1'b0, ad_b});
    bd = longint'({1'b0, bd_b});
    f = '{num: 32'd0, den: 31'd1, sts: rau_pkg::STS_DIV0};
    if (ad == 0 || bd == 0) return f;
    case (op)
      rau_pkg::OP_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
      rau_pkg::OP_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
      rau_pkg::OP_MUL: begin rn = an * bn; rd = ad * bd; end
      default: begin
        if (bn == 0) return f;
        rn = an * bd;
        rd = ad * bn;
      end
    endcase
    neg = (rn < 0) != (rd < 0);
    if (rn < 0) rn = -rn;
    if (rd < 0) rd = -rd;
    f.sts = rau_pkg::STS_OK;
    if (rn == 0) return f;
    p = rn;
    q = rd;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    rn = rn / p;
    rd = rd / p;
    if (rd > 64'h7fffffff || (neg ? rn > 64'h80000000 : rn > 64'h7fffffff)) begin
      f.sts = rau_pkg::STS_OVF;
      return f;
    end
    f.num = neg ? -rn[31:0] : rn[31:0];
    f.den = rd[30:0];
    return f;
  endfunction

  function void note_operands(rau_pkg::rau_op_e op, logic [31:0] an, logic [30:0] ad,
                              logic [31:0] bn, logic [30:0] bd);
    pending.push_back(reduce_fraction(op, an, ad, bn, bd));
  endfunction

  function bit check_result(logic [31:0] num, logic [30:0] den, logic [1:0] sts,
                            output string msg);
    frac_t e;
    if (pending.size() == 0) begin
      msg = $sformatf("unexpected result %0d/%0d status %0d", $signed(num), den, sts);
      return 0;
    end
    e = pending.pop_front();
    checked++;
    if (e.num !== num || e.den !== den || e.sts !== sts) begin
      msg = $sformatf("result %0d/%0d status %0d, predicted %0d/%0d status %0d",
                      $signed(num), den, sts, $signed(e.num), e.den, e.sts);
      return 0;
    end
    return 1;
  endfunction
endclass

module rational_arithmetic_unit_core_test;
  import rau_pkg::*;

  localparam int NumRandom = 1250;
  localparam int IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   idle_cycles;
  int   sent;
  int   counts[4];
  bit   long_stall;
  rau_scoreboard fraction_board;

  rau_in_if  #(.W(32)) in_i ();
  rau_out_if #(.W(32)) out_o ();

  rational_arithmetic_unit_core #(.VALUE_WIDTH(32)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i.sink),
    .out_o (out_o.source)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_operands(rau_op_e op, logic [31:0] an, logic [30:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
    in_i.valid         <= 1'b1;
    in_i.operation     <= op;
    in_i.a_numerator   <= an;
    in_i.a_denominator <= ad;
    in_i.b_numerator   <= bn;
    in_i.b_denominator <= bd;
    do @(posedge clk_i); while (!in_i.ready);
    fraction_board.note_operands(op, an, ad, bn, bd);
    counts[op]++;
    sent++;
  endtask

  task automatic pause_sender(int n);
    in_i.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_numerator();
    case ($urandom_range(0, 5))
      0: return 32'h80000000 | $urandom_range(0, 3);
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 40) - 20;
      3: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_denominator();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'(32'h7fffffff - $urandom_range(0, 3));
      2, 3: return 31'($urandom_range(1, 30));
      default: return 31'($urandom);
    endcase
  endfunction

  // result side: stall pattern plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else if (long_stall) begin
      out_o.ready <= 1'b0;
    end else begin
      out_o.ready <= (sent % 200 < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (!fraction_board.check_result(out_o.result_numerator, out_o.result_denominator,
                                       out_o.status, msg))
        report(msg);
    end
    if (rst_ni && !((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)))
      idle_cycles++;
    else
      idle_cycles = 0;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("rational_arithmetic_unit_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int burst;
    int i;
    fraction_board = new();
    mismatches = 0;
    idle_cycles = 0;
    sent = 0;
    long_stall = 1'b0;
    rst_ni = 1'b0;
    in_i.valid <= 1'b0;
    in_i.operation <= OP_ADD;
    in_i.a_numerator <= '0;
    in_i.a_denominator <= '0;
    in_i.b_numerator <= '0;
    in_i.b_denominator <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_operands(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_operands(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    send_operands(OP_MUL, 32'h80000000, 31'd1, 32'h80000000, 31'd1);
    send_operands(OP_MUL, 32'h80000000, 31'd1, 32'd1, 31'd1);
    send_operands(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd1);
    send_operands(OP_DIV, 32'hfffffffd, 31'd4, 32'hfffffffe, 31'd3);
    send_operands(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    send_operands(OP_MUL, 32'd1, 31'd1, 32'd1, 31'd0);
    send_operands(OP_ADD, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1);
    send_operands(OP_SUB, 32'h80000000, 31'd1, 32'd1, 31'd1);
    send_operands(OP_ADD, 32'd1, 31'h7fffffff, 32'd1, 31'h7ffffffe);
    send_operands(OP_DIV, 32'h7fffffff, 31'd1, 32'd1, 31'h7fffffff);
    send_operands(OP_DIV, 32'd1, 31'h7fffffff, 32'h80000000, 31'd1);
    send_operands(OP_SUB, 32'd4, 31'd6, 32'd2, 31'd3);
    send_operands(OP_MUL, 32'd0, 31'h7fffffff, 32'h80000000, 31'd7);
    send_operands(OP_DIV, 32'd2, 31'd4, 32'd6, 31'd8);
    send_operands(OP_ADD, 32'hffffffff, 31'h7fffffff, 32'h7fffffff, 31'h55555555);

    // long hold-off on the result side while operands keep coming
    fork
      begin
        long_stall = 1'b1;
        repeat (3000) @(posedge clk_i);
        long_stall = 1'b0;
      end
      for (int k = 0; k < 6; k++)
        send_operands(rau_op_e'($urandom_range(0, 3)), pick_numerator(), pick_denominator(),
                      pick_numerator(), pick_denominator());
    join

    i = 0;
    while (i < NumRandom) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && i < NumRandom; k++, i++)
        send_operands(rau_op_e'($urandom_range(0, 3)), pick_numerator(), pick_denominator(),
                      pick_numerator(), pick_denominator());
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 150));
    end
    in_i.valid <= 1'b0;

    while (fraction_board.pending.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);

    $display("sent %0d operand beats: %0d add, %0d sub, %0d mul, %0d div",
             sent, counts[OP_ADD], counts[OP_SUB], counts[OP_MUL], counts[OP_DIV]);
    $display("checked %0d result beats with %0d mismatches",
             fraction_board.checked, mismatches);
    if (mismatches == 0)
      $display("rational_arithmetic_unit_core_test OK");
    else
      $display("rational_arithmetic_unit_core_test NOT OK");
    $finish;
  end
endmodule

`default_nettype wire
